// ===== rtl/pva_pkg.sv =====
// Shared types, constants and microcode field codes for the polyphonic voice allocator.
// Used by every module of the block; depends on nothing else.
package pva_pkg;

  localparam int VOICE_COUNT = 4;
  localparam int VIW         = $clog2(VOICE_COUNT);      // voice index width
  localparam int CW          = $clog2(VOICE_COUNT + 1);  // scan pointer, can hold VOICE_COUNT
  localparam int NOTE_W      = 7;
  localparam int VOICE_W     = 4;
  localparam int ORD_W       = 5;
  localparam int STEP_W      = 5;

  localparam logic [ORD_W-1:0] EMPTY_SLOT = 5'd31;

  localparam logic [1:0] MODE_POLY      = 2'd0;
  localparam logic [1:0] MODE_LEAD_LOW  = 2'd1;
  localparam logic [1:0] MODE_LEAD_HIGH = 2'd2;

  localparam logic [NOTE_W-1:0] BORDER_RESET = 7'd60;

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram step addresses.
  localparam step_t ST_IDLE      = 5'd0;
  localparam step_t ST_CHK_LOFF  = 5'd1;
  localparam step_t ST_CHK_LON   = 5'd2;
  localparam step_t ST_CHK_ZERO  = 5'd3;
  localparam step_t ST_CHK_KIND  = 5'd4;
  localparam step_t ST_OFF_FIND  = 5'd5;
  localparam step_t ST_OFF_CLR   = 5'd6;
  localparam step_t ST_OFF_ORD   = 5'd7;
  localparam step_t ST_OFF_SHIFT = 5'd8;
  localparam step_t ST_OFF_TAIL  = 5'd9;
  localparam step_t ST_ON_FIND   = 5'd10;
  localparam step_t ST_ON_FREE   = 5'd11;
  localparam step_t ST_ON_ENTER  = 5'd12;
  localparam step_t ST_ON_STEAL  = 5'd13;
  localparam step_t ST_ON_SHIFT  = 5'd14;
  localparam step_t ST_ON_TAIL   = 5'd15;
  localparam step_t ST_ON_SET    = 5'd16;
  localparam step_t ST_REPORT    = 5'd17;
  localparam step_t ST_NO_CHANGE = 5'd18;
  localparam step_t ST_LEAD_OFF  = 5'd19;
  localparam step_t ST_LEAD_CLR  = 5'd20;
  localparam step_t ST_LEAD_ON   = 5'd21;

  typedef enum logic [3:0] {
    C_NEVER        = 4'd0,
    C_ALWAYS       = 4'd1,
    C_IN_VALID     = 4'd2,
    C_OFF_LEAD     = 4'd3,
    C_ON_LEAD      = 4'd4,
    C_NOTE_ZERO    = 4'd5,
    C_KIND_ON      = 4'd6,
    C_ACT_EQ_NOTE  = 4'd7,
    C_ACT_ZERO     = 4'd8,
    C_ORD_EQ_VOICE = 4'd9,
    C_ORD_EMPTY    = 4'd10,
    C_OUT_FREE     = 4'd11
  } cond_t;

  typedef enum logic [2:0] {
    P_HOLD   = 3'd0,
    P_LO     = 3'd1,
    P_INC    = 3'd2,
    P_LO_INC = 3'd3,
    P_SCAN   = 3'd4
  } ptr_op_t;

  typedef enum logic [1:0] {
    CAP_NONE  = 2'd0,
    CAP_PTR   = 2'd1,
    CAP_STEAL = 2'd2,
    CAP_LEAD  = 2'd3
  } cap_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_CLR  = 2'd1,
    ACT_NOTE = 2'd2
  } act_wr_t;

  typedef enum logic [2:0] {
    ORD_NONE       = 3'd0,
    ORD_FILL       = 3'd1,
    ORD_SHIFT      = 3'd2,
    ORD_TAIL_EMPTY = 3'd3,
    ORD_TAIL_VOICE = 3'd4
  } ord_wr_t;

  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_CLR  = 2'd1,
    LEAD_NOTE = 2'd2
  } lead_wr_t;

  typedef enum logic [1:0] {
    REP_NONE  = 2'd0,
    REP_VOICE = 2'd1,
    REP_NULL  = 2'd2
  } rep_t;

  // One control word of the microprogram.
  typedef struct packed {
    cond_t    cond;
    step_t    tgt;
    logic     end_chk;
    step_t    alt;
    logic     loop;
    ptr_op_t  ptr_op;
    cap_t     cap;
    act_wr_t  act_wr;
    logic     held_wr;
    ord_wr_t  ord_wr;
    lead_wr_t lead_wr;
    rep_t     rep;
  } pva_ctl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic off_lead;
    logic on_lead;
    logic note_zero;
    logic kind_on;
    logic act_eq_note;
    logic act_zero;
    logic ord_eq_voice;
    logic ord_empty;
    logic ptr_end;
    logic out_free;
  } pva_flags_t;

  // Branch outcome of the current step, fed back to the datapath.
  typedef struct packed {
    logic cond_hit;
    logic end_hit;
  } pva_branch_t;

  typedef struct packed {
    logic              kind;
    logic [NOTE_W-1:0] note;
  } pva_in_t;

  typedef struct packed {
    logic               changed;
    logic [VOICE_W-1:0] voice;
    logic [NOTE_W-1:0]  latched_note;
    logic               gate;
  } pva_out_t;

endpackage

// ===== rtl/poly_voice_allocator_lru.sv =====
// Top level of the polyphonic voice allocator with oldest-first voice stealing.
// Depends on pva_pkg, pva_ucode_rom, pva_sequencer and pva_datapath.
//
//   Channel   Direction  Handshake                  Carries
//   in_       input      in_valid / in_ready        pva_in_t: kind, note
//   out_      output     out_valid / out_ready      pva_out_t: changed, voice, latched_note, gate
//   APB       config     psel/penable/pwrite/pready mode at 0x0, lead_border at 0x4
//
// An event is shortest for a lead release or an ignored note and longest for a stealing
// note-on; the sequencer returns to its idle step after each result before taking the next one.
// The microcode walks the voice and age tables one entry per cycle in up to three scans.
// Reset is synchronous and active low; it clears voices, age order and lead note and sets
// mode 0 and border 60. A new event is taken at the idle step even while a result waits in
// the output register; a stalled output holds the sequencer only at its report steps.

module poly_voice_allocator_lru import pva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  pva_in_t     in_data,

  output logic        out_valid,
  input  logic        out_ready,
  output pva_out_t    out_data,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Registers sit on word addresses; bit 2 of the address selects between them.
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_BORDER = 1'b1;

  logic [1:0]        mode_r;
  logic [NOTE_W-1:0] border_r;
  logic              cfg_wr;

  step_t       pc;
  pva_ctl_t    ctl;
  pva_flags_t  flags;
  pva_branch_t br;
  logic        in_acc;

  // The APB port never inserts wait states. A register is written in the access
  // phase of a write transfer.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_POLY;
      border_r <= BORDER_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODE) begin
        mode_r <= pwdata[1:0];
      end else begin
        border_r <= pwdata[NOTE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_BORDER) ? 32'(border_r) : 32'(mode_r);

  // The sequencer takes a new event only from its idle step; the event is latched in
  // the datapath on the transfer.
  assign in_ready = (pc == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  pva_ucode_rom u_rom (
    .pc  (pc),
    .ctl (ctl)
  );

  pva_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .flags (flags),
    .pc    (pc),
    .br    (br)
  );

  pva_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .br        (br),
    .in_valid  (in_valid),
    .in_acc    (in_acc),
    .in_data   (in_data),
    .mode      (mode_r),
    .border    (border_r),
    .out_ready (out_ready),
    .flags     (flags),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/pva_ucode_rom.sv =====
// Microprogram store of the voice allocator: one control word per step address.
// Depends on pva_pkg for the control word layout and step addresses.
module pva_ucode_rom import pva_pkg::*; (
  input  step_t    pc,
  output pva_ctl_t ctl
);

  always_comb begin
    ctl = '0;
    unique case (pc)
      ST_IDLE: begin
        ctl.cond = C_IN_VALID;
        ctl.tgt  = ST_CHK_LOFF;
        ctl.loop = 1'b1;
      end
      ST_CHK_LOFF: begin
        ctl.cond = C_OFF_LEAD;
        ctl.tgt  = ST_LEAD_OFF;
      end
      ST_CHK_LON: begin
        ctl.cond = C_ON_LEAD;
        ctl.tgt  = ST_LEAD_ON;
      end
      ST_CHK_ZERO: begin
        ctl.cond   = C_NOTE_ZERO;
        ctl.tgt    = ST_NO_CHANGE;
        ctl.ptr_op = P_LO;
      end
      ST_CHK_KIND: begin
        ctl.cond = C_KIND_ON;
        ctl.tgt  = ST_ON_FIND;
      end
      ST_OFF_FIND: begin
        ctl.cond    = C_ACT_EQ_NOTE;
        ctl.tgt     = ST_OFF_CLR;
        ctl.end_chk = 1'b1;
        ctl.alt     = ST_NO_CHANGE;
        ctl.loop    = 1'b1;
        ctl.ptr_op  = P_SCAN;
        ctl.cap     = CAP_PTR;
      end
      ST_OFF_CLR: begin
        ctl.act_wr = ACT_CLR;
        ctl.ptr_op = P_LO;
      end
      ST_OFF_ORD: begin
        ctl.cond    = C_ORD_EQ_VOICE;
        ctl.tgt     = ST_OFF_SHIFT;
        ctl.end_chk = 1'b1;
        ctl.alt     = ST_REPORT;
        ctl.loop    = 1'b1;
        ctl.ptr_op  = P_INC;
      end
      ST_OFF_SHIFT: begin
        ctl.end_chk = 1'b1;
        ctl.alt     = ST_OFF_TAIL;
        ctl.loop    = 1'b1;
        ctl.ptr_op  = P_INC;
        ctl.ord_wr  = ORD_SHIFT;
      end
      ST_OFF_TAIL: begin
        ctl.cond   = C_ALWAYS;
        ctl.tgt    = ST_REPORT;
        ctl.ord_wr = ORD_TAIL_EMPTY;
      end
      ST_ON_FIND: begin
        ctl.cond    = C_ACT_EQ_NOTE;
        ctl.tgt     = ST_NO_CHANGE;
        ctl.end_chk = 1'b1;
        ctl.alt     = ST_ON_FREE;
        ctl.loop    = 1'b1;
        ctl.ptr_op  = P_SCAN;
      end
      ST_ON_FREE: begin
        ctl.cond    = C_ACT_ZERO;
        ctl.tgt     = ST_ON_ENTER;
        ctl.end_chk = 1'b1;
        ctl.alt     = ST_ON_STEAL;
        ctl.loop    = 1'b1;
        ctl.ptr_op  = P_SCAN;
        ctl.cap     = CAP_PTR;
      end
      ST_ON_ENTER: begin
        ctl.cond    = C_ORD_EMPTY;
        ctl.tgt     = ST_ON_SET;
        ctl.end_chk = 1'b1;
        ctl.alt     = ST_ON_SET;
        ctl.loop    = 1'b1;
        ctl.ptr_op  = P_INC;
        ctl.ord_wr  = ORD_FILL;
      end
      ST_ON_STEAL: begin
        ctl.ptr_op = P_LO_INC;
        ctl.cap    = CAP_STEAL;
      end
      ST_ON_SHIFT: begin
        ctl.end_chk = 1'b1;
        ctl.alt     = ST_ON_TAIL;
        ctl.loop    = 1'b1;
        ctl.ptr_op  = P_INC;
        ctl.ord_wr  = ORD_SHIFT;
      end
      ST_ON_TAIL: begin
        ctl.ord_wr = ORD_TAIL_VOICE;
      end
      ST_ON_SET: begin
        ctl.cond    = C_ALWAYS;
        ctl.tgt     = ST_REPORT;
        ctl.act_wr  = ACT_NOTE;
        ctl.held_wr = 1'b1;
      end
      ST_REPORT: begin
        ctl.cond = C_OUT_FREE;
        ctl.tgt  = ST_IDLE;
        ctl.loop = 1'b1;
        ctl.rep  = REP_VOICE;
      end
      ST_NO_CHANGE: begin
        ctl.cond = C_OUT_FREE;
        ctl.tgt  = ST_IDLE;
        ctl.loop = 1'b1;
        ctl.rep  = REP_NULL;
      end
      ST_LEAD_OFF: begin
        ctl.cap     = CAP_LEAD;
        ctl.lead_wr = LEAD_CLR;
      end
      ST_LEAD_CLR: begin
        ctl.cond   = C_ALWAYS;
        ctl.tgt    = ST_REPORT;
        ctl.act_wr = ACT_CLR;
      end
      ST_LEAD_ON: begin
        ctl.cond    = C_ALWAYS;
        ctl.tgt     = ST_ON_SET;
        ctl.cap     = CAP_LEAD;
        ctl.lead_wr = LEAD_NOTE;
      end
      default: begin
        ctl.cond = C_ALWAYS;
        ctl.tgt  = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pva_sequencer.sv =====
// Step counter of the voice allocator: evaluates the branch condition of the current
// control word and picks the next step. Depends on pva_pkg.
module pva_sequencer import pva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pva_ctl_t    ctl,
  input  pva_flags_t  flags,
  output step_t       pc,
  output pva_branch_t br
);

  step_t pc_r;
  step_t pc_nxt;
  logic  cond_true;

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:        cond_true = 1'b0;
      C_ALWAYS:       cond_true = 1'b1;
      C_IN_VALID:     cond_true = flags.in_valid;
      C_OFF_LEAD:     cond_true = flags.off_lead;
      C_ON_LEAD:      cond_true = flags.on_lead;
      C_NOTE_ZERO:    cond_true = flags.note_zero;
      C_KIND_ON:      cond_true = flags.kind_on;
      C_ACT_EQ_NOTE:  cond_true = flags.act_eq_note;
      C_ACT_ZERO:     cond_true = flags.act_zero;
      C_ORD_EQ_VOICE: cond_true = flags.ord_eq_voice;
      C_ORD_EMPTY:    cond_true = flags.ord_empty;
      C_OUT_FREE:     cond_true = flags.out_free;
      default:        cond_true = 1'b0;
    endcase
  end

  // The end of a scan takes priority over a hit in the same cycle.
  assign br.end_hit  = ctl.end_chk && flags.ptr_end;
  assign br.cond_hit = cond_true && !br.end_hit;

  always_comb begin
    if (br.end_hit) begin
      pc_nxt = ctl.alt;
    end else if (br.cond_hit) begin
      pc_nxt = ctl.tgt;
    end else if (ctl.loop) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = step_t'(pc_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign pc = pc_r;

endmodule

// ===== rtl/pva_datapath.sv =====
// Datapath of the voice allocator: voice note tables, age order, lead note, scan pointer,
// captured event and result register, all steered by the control word. Depends on pva_pkg.
module pva_datapath import pva_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pva_ctl_t          ctl,
  input  pva_branch_t       br,
  input  logic              in_valid,
  input  logic              in_acc,
  input  pva_in_t           in_data,
  input  logic [1:0]        mode,
  input  logic [NOTE_W-1:0] border,
  input  logic              out_ready,
  output pva_flags_t        flags,
  output logic              out_valid,
  output pva_out_t          out_data
);

  logic              kind_r;
  logic [NOTE_W-1:0] note_r;
  logic [NOTE_W-1:0] act_r  [VOICE_COUNT];
  logic [NOTE_W-1:0] held_r [VOICE_COUNT];
  logic [ORD_W-1:0]  ord_r  [VOICE_COUNT];
  logic [NOTE_W-1:0] lead_r;
  logic [CW-1:0]     ptr_r;
  logic [CW-1:0]     ptr_nxt;
  logic [VIW-1:0]    voice_r;
  logic [VIW-1:0]    voice_nxt;
  logic              out_valid_r;
  pva_out_t          out_data_r;

  logic              lead1;
  logic              lead2;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [VIW-1:0]    lead_v;
  logic [VIW-1:0]    ptr_idx;
  logic [VIW-1:0]    prev_idx;
  logic [VIW-1:0]    tail_idx;
  logic [VIW-1:0]    act_addr;
  logic [NOTE_W-1:0] act_rd;
  logic [NOTE_W-1:0] held_rd;
  logic [ORD_W-1:0]  ord_rd;
  logic              steal_ok;
  logic [VIW-1:0]    steal_v;
  logic              out_free;

  assign lead1  = (mode == MODE_LEAD_LOW);
  assign lead2  = (mode == MODE_LEAD_HIGH);
  assign lo     = lead1 ? CW'(1) : '0;
  assign hi     = lead2 ? CW'(VOICE_COUNT - 1) : CW'(VOICE_COUNT);
  assign lead_v = lead1 ? '0 : VIW'(VOICE_COUNT - 1);

  assign ptr_idx  = ptr_r[VIW-1:0];
  assign prev_idx = VIW'(ptr_r - 1'b1);
  assign tail_idx = VIW'(hi - 1'b1);

  // The note table has one read port: the scan pointer, or the chosen voice when reporting.
  assign act_addr = (ctl.rep == REP_VOICE) ? voice_r : ptr_idx;
  assign act_rd   = act_r[act_addr];
  assign held_rd  = held_r[voice_r];
  assign ord_rd   = ord_r[ptr_idx];

  // The oldest entry is stolen only when it names a voice inside the active range.
  assign steal_ok = (ord_rd >= ORD_W'(lo)) && (ord_rd < ORD_W'(hi));
  assign steal_v  = steal_ok ? ord_rd[VIW-1:0] : lo[VIW-1:0];

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    flags.in_valid     = in_valid;
    flags.off_lead     = !kind_r && (lead1 || lead2) && (note_r == lead_r);
    flags.on_lead      = kind_r && ((lead1 && (note_r < border)) ||
                                    (lead2 && (note_r >= border)));
    flags.note_zero    = (note_r == '0);
    flags.kind_on      = kind_r;
    flags.act_eq_note  = (act_rd == note_r);
    flags.act_zero     = (act_rd == '0);
    flags.ord_eq_voice = (ord_rd == ORD_W'(voice_r));
    flags.ord_empty    = (ord_rd == EMPTY_SLOT);
    flags.ptr_end      = (ptr_r == hi);
    flags.out_free     = out_free;
  end

  always_comb begin
    unique case (ctl.ptr_op)
      P_HOLD:   ptr_nxt = ptr_r;
      P_LO:     ptr_nxt = lo;
      P_INC:    ptr_nxt = CW'(ptr_r + 1'b1);
      P_LO_INC: ptr_nxt = CW'(lo + 1'b1);
      P_SCAN:   ptr_nxt = (br.end_hit || br.cond_hit) ? lo : CW'(ptr_r + 1'b1);
      default:  ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    unique case (ctl.cap)
      CAP_NONE:  voice_nxt = voice_r;
      CAP_PTR:   voice_nxt = br.cond_hit ? ptr_idx : voice_r;
      CAP_STEAL: voice_nxt = steal_v;
      CAP_LEAD:  voice_nxt = lead_v;
      default:   voice_nxt = voice_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_data.kind;
      note_r <= in_data.note;
    end
    ptr_r   <= ptr_nxt;
    voice_r <= voice_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        act_r[i]  <= '0;
        held_r[i] <= '0;
        ord_r[i]  <= EMPTY_SLOT;
      end
      lead_r <= '0;
    end else begin
      unique case (ctl.act_wr)
        ACT_NONE: ;
        ACT_CLR:  act_r[voice_r] <= '0;
        ACT_NOTE: act_r[voice_r] <= note_r;
        default: ;
      endcase
      if (ctl.held_wr) begin
        held_r[voice_r] <= note_r;
      end
      unique case (ctl.ord_wr)
        ORD_NONE: ;
        ORD_FILL: begin
          if (br.cond_hit) begin
            ord_r[ptr_idx] <= ORD_W'(voice_r);
          end
        end
        ORD_SHIFT: begin
          if (!br.end_hit) begin
            ord_r[prev_idx] <= ord_rd;
          end
        end
        ORD_TAIL_EMPTY: ord_r[tail_idx] <= EMPTY_SLOT;
        ORD_TAIL_VOICE: ord_r[tail_idx] <= ORD_W'(voice_r);
        default: ;
      endcase
      unique case (ctl.lead_wr)
        LEAD_NONE: ;
        LEAD_CLR:  lead_r <= '0;
        LEAD_NOTE: lead_r <= note_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctl.rep != REP_NONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.rep != REP_NONE) && out_free) begin
      if (ctl.rep == REP_VOICE) begin
        out_data_r.changed      <= 1'b1;
        out_data_r.voice        <= VOICE_W'(voice_r);
        out_data_r.latched_note <= held_rd;
        out_data_r.gate         <= (act_rd != '0);
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
